// File: rtl/core/sqrot_pkg.sv
// ----------------------------------------------------------------------------
// sqrot_pkg
// Shared types and constants for the square tile rotation unit.
// ----------------------------------------------------------------------------
package sqrot_pkg;

  // Default tile edge limit and element width.
  localparam int MAX_EDGE_DEF   = 64;
  localparam int ELEM_WIDTH_DEF = 16;

  // Width of the tile size register and its value after reset.
  localparam int               CFG_W         = 7;
  localparam logic [CFG_W-1:0] TILE_SIZE_RST = 7'd64;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Control bits that go with each command.
  typedef struct packed {
    logic emit;      // a result is produced for this beat
    logic tile_end;  // the result is the last element of its tile
  } cmd_ctl_t;

endpackage

// File: rtl/core/sqrot_ram.sv
// ----------------------------------------------------------------------------
// sqrot_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sqrot_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/sqrot_front.sv
// ----------------------------------------------------------------------------
// sqrot_front
// Accepts input beats, tracks the write position and bank, and builds one
// command per beat with the write address, the rotated read address and flags.
// ----------------------------------------------------------------------------
module sqrot_front #(
  parameter int MAX_EDGE   = sqrot_pkg::MAX_EDGE_DEF,
  parameter int ELEM_WIDTH = sqrot_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write.
  input  logic                                cfg_we,
  input  logic [sqrot_pkg::CFG_W-1:0]         cfg_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ELEM_WIDTH-1:0]               in_pixel,
  // Command output to the queue.
  input  logic                                q_full,
  output logic                                cmd_push,
  output sqrot_pkg::cmd_ctl_t                 cmd_ctl,
  output logic [2*$clog2(MAX_EDGE):0]         cmd_wr_addr,
  output logic [2*$clog2(MAX_EDGE):0]         cmd_rd_addr,
  output logic [ELEM_WIDTH-1:0]               cmd_data
);
  import sqrot_pkg::*;

  localparam int RC_W = $clog2(MAX_EDGE);
  localparam int SW   = (CFG_W > RC_W + 1) ? CFG_W : RC_W + 1;

  // Last valid row or column index for a tile size, with zero taken as one
  // and large sizes clipped to the edge limit.
  function automatic logic [RC_W-1:0] last_of(input logic [CFG_W-1:0] ts);
    logic [SW-1:0] e;
    begin
      e = SW'(ts);
      if (ts == '0) begin
        last_of = '0;
      end else if (e > SW'(MAX_EDGE)) begin
        last_of = RC_W'(MAX_EDGE - 1);
      end else begin
        last_of = RC_W'(e - SW'(1));
      end
    end
  endfunction

  logic [RC_W-1:0] last_r, last_nxt;
  logic [RC_W-1:0] row_r, row_nxt;
  logic [RC_W-1:0] col_r, col_nxt;
  logic            bank_r, bank_nxt;
  logic            full_r, full_nxt;
  logic            accept;
  logic            col_wrap;
  logic            row_wrap;
  logic [RC_W-1:0] src_row;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Position bookkeeping.
  assign col_wrap = (col_r == last_r);
  assign row_wrap = (row_r == last_r);

  always_comb begin
    last_nxt = last_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    bank_nxt = bank_r;
    full_nxt = full_r;
    if (cfg_we) begin
      last_nxt = last_of(cfg_data);
      row_nxt  = '0;
      col_nxt  = '0;
      full_nxt = 1'b0;
    end else if (accept) begin
      if (!col_wrap) begin
        col_nxt = col_r + RC_W'(1);
      end else begin
        col_nxt = '0;
        if (!row_wrap) begin
          row_nxt = row_r + RC_W'(1);
        end else begin
          row_nxt  = '0;
          bank_nxt = !bank_r;
          full_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= last_of(TILE_SIZE_RST);
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      bank_r <= bank_nxt;
      full_r <= full_nxt;
    end
  end

  // Command build: the output at (r, c) comes from (n-1-c, r) of the held tile.
  assign src_row          = last_r - col_r;
  assign cmd_push         = accept;
  assign cmd_ctl.emit     = full_r;
  assign cmd_ctl.tile_end = col_wrap && row_wrap;
  assign cmd_wr_addr      = {bank_r, row_r, col_r};
  assign cmd_rd_addr      = {!bank_r, src_row, row_r};
  assign cmd_data         = in_pixel;

endmodule

// File: rtl/core/sqrot_queue.sv
// ----------------------------------------------------------------------------
// sqrot_queue
// Short register FIFO that carries commands from the front to the back.
// ----------------------------------------------------------------------------
module sqrot_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import sqrot_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // A push that meets a full queue would drop a command.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into full queue");
`endif

endmodule

// File: rtl/core/sqrot_back.sv
// ----------------------------------------------------------------------------
// sqrot_back
// Executes commands: writes the element to its bank, reads the rotated
// element from the other bank and delivers it through an output register.
// ----------------------------------------------------------------------------
module sqrot_back #(
  parameter int MAX_EDGE   = sqrot_pkg::MAX_EDGE_DEF,
  parameter int ELEM_WIDTH = sqrot_pkg::ELEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Command from the queue.
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  sqrot_pkg::cmd_ctl_t         cmd_ctl,
  input  logic [2*$clog2(MAX_EDGE):0] cmd_wr_addr,
  input  logic [2*$clog2(MAX_EDGE):0] cmd_rd_addr,
  input  logic [ELEM_WIDTH-1:0]       cmd_data,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ELEM_WIDTH-1:0]       out_pixel,
  output logic                        out_tile_end
);
  import sqrot_pkg::*;

  localparam int AW    = 2 * $clog2(MAX_EDGE) + 1;
  localparam int DEPTH = 2 ** AW;

  logic                  s1_vld_r, s1_vld_nxt;
  logic                  s1_end_r;
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_end_r;
  logic [ELEM_WIDTH-1:0] out_pix_r;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic                  s1_move;
  logic                  s1_free;
  logic                  rd_issue;

  // Stage 1 holds a read in flight; it moves when the output register frees.
  assign s1_move  = s1_vld_r && (!out_vld_r || out_ready);
  assign s1_free  = !s1_vld_r || s1_move;
  assign cmd_pop  = cmd_valid && (!cmd_ctl.emit || s1_free);
  assign rd_issue = cmd_pop && cmd_ctl.emit;

  // Both tile banks live in one RAM, the bank bit being the top address bit.
  sqrot_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_banks (
    .clk     (clk),
    .wr_en   (cmd_pop),
    .wr_addr (cmd_wr_addr),
    .wr_data (cmd_data),
    .rd_en   (rd_issue),
    .rd_addr (cmd_rd_addr),
    .rd_data (rd_data)
  );

  assign s1_vld_nxt  = rd_issue || (s1_vld_r && !s1_move);
  assign out_vld_nxt = s1_move || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      s1_end_r <= cmd_ctl.tile_end;
    end
    if (s1_move) begin
      out_pix_r <= rd_data;
      out_end_r <= s1_end_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_pixel    = out_pix_r;
  assign out_tile_end = out_end_r;

`ifndef SYNTHESIS
  // A new read never lands on a read result that has not moved on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_issue && s1_vld_r) |-> s1_move)
    else $error("read issued over pending read data");

  // A stalled read result stays in stage 1 until the output takes it.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |=> s1_vld_r)
    else $error("pending read result lost");
`endif

endmodule

// File: rtl/core/square_tile_rotate_90_unit.sv
// Path: an accepted beat passes the command queue, the bank RAM read register
//   and the output register; a stall at the output holds it there.
// Throughput: one beat per cycle without stalls, set by the single write and
//   read port pair of the tile bank RAM; a two-entry command queue decouples them.
// Reset: synchronous, active low; tile banks are not cleared, the first tile
//   after reset or a size write produces no results.
// ----------------------------------------------------------------------------
// square_tile_rotate_90_unit
// Streaming 90 degree clockwise rotation of square tiles using ping-pong
// banks: a front builds commands, a queue buffers them, a back executes them.
// ----------------------------------------------------------------------------
module square_tile_rotate_90_unit #(
  parameter int MAX_EDGE   = sqrot_pkg::MAX_EDGE_DEF,
  parameter int ELEM_WIDTH = sqrot_pkg::ELEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sqrot_pkg::CFG_W-1:0] cfg_tile_size,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ELEM_WIDTH-1:0]       in_pixel_in,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ELEM_WIDTH-1:0]       out_pixel_out,
  output logic                        out_tile_end
);
  import sqrot_pkg::*;

  localparam int AW = 2 * $clog2(MAX_EDGE) + 1;
  localparam int QW = $bits(cmd_ctl_t) + 2 * AW + ELEM_WIDTH;

  logic                  cfg_we;
  logic                  q_full;
  logic                  f_push;
  cmd_ctl_t              f_ctl;
  logic [AW-1:0]         f_wr_addr;
  logic [AW-1:0]         f_rd_addr;
  logic [ELEM_WIDTH-1:0] f_data;
  logic [QW-1:0]         q_in;
  logic [QW-1:0]         q_out;
  logic                  q_valid;
  logic                  q_pop;
  cmd_ctl_t              b_ctl;
  logic [AW-1:0]         b_wr_addr;
  logic [AW-1:0]         b_rd_addr;
  logic [ELEM_WIDTH-1:0] b_data;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sqrot_front #(
    .MAX_EDGE   (MAX_EDGE),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_tile_size),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel    (in_pixel_in),
    .q_full      (q_full),
    .cmd_push    (f_push),
    .cmd_ctl     (f_ctl),
    .cmd_wr_addr (f_wr_addr),
    .cmd_rd_addr (f_rd_addr),
    .cmd_data    (f_data)
  );

  // Command packing across the queue.
  assign q_in = {f_ctl, f_wr_addr, f_rd_addr, f_data};
  assign {b_ctl, b_wr_addr, b_rd_addr, b_data} = q_out;

  sqrot_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  sqrot_back #(
    .MAX_EDGE   (MAX_EDGE),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .cmd_ctl      (b_ctl),
    .cmd_wr_addr  (b_wr_addr),
    .cmd_rd_addr  (b_rd_addr),
    .cmd_data     (b_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel_out),
    .out_tile_end (out_tile_end)
  );

endmodule

// File: tb/square_tile_rotate_90_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_tile_rotate_90_unit_tb
// Self-checking bench for the streaming tile rotator. Random pixels are sent
// through the input handshake, a behavioral copy of the two tile banks
// predicts every rotated pixel and tile end, and a monitor compares each
// result beat against the oldest prediction. Both sides idle at random, and
// the tile size register is rewritten between phases, its extremes included.
// ----------------------------------------------------------------------------
module square_tile_rotate_90_unit_tb;

  import sqrot_pkg::*;

  localparam int MAX_EDGE   = MAX_EDGE_DEF;
  localparam int ELEM_WIDTH = ELEM_WIDTH_DEF;
  localparam int BANK_DEPTH = MAX_EDGE * MAX_EDGE;
  localparam int RUN_LIMIT  = 1_000_000;
  localparam int SETTLE_CYC = 8;
  localparam int MAX_PRINTS = 40;

  // Total pixels for the run and the share kept for the saturated size.
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned SAT_ITEMS   = 40;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] pixel;
    logic                  tile_end;
  } rot_beat_t;

  // Block ports. Every input starts at a known value.
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_tile_size = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [ELEM_WIDTH-1:0] in_pixel_in   = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [ELEM_WIDTH-1:0] out_pixel_out;
  logic                  out_tile_end;

  // Pixels waiting to be sent and rotated pixels waiting to come out.
  logic [ELEM_WIDTH-1:0] pixel_q[$];
  rot_beat_t             rotated_q[$];

  // Behavioral copy of the tile banks and the write position.
  logic [ELEM_WIDTH-1:0] rot_mem[2][BANK_DEPTH];
  logic [CFG_W-1:0]      rot_size = TILE_SIZE_RST;
  int unsigned           rot_row  = 0;
  int unsigned           rot_col  = 0;
  bit                    rot_bank = 1'b0;
  bit                    rot_held = 1'b0;

  // Handshake pacing and run statistics.
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned tile_ends    = 0;
  int unsigned size_writes  = 0;

  square_tile_rotate_90_unit #(
    .MAX_EDGE  (MAX_EDGE),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_tile_size(cfg_tile_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .out_tile_end (out_tile_end)
  );

  // Free-running clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Effective edge length: zero acts as one, large sizes saturate.
  function automatic int unsigned clamp_edge(input logic [CFG_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_EDGE) return MAX_EDGE;
    return size;
  endfunction

  // Writes one pixel into the current bank and queues the rotated pixel
  // read from the other bank when that bank holds a complete tile.
  task automatic predict_rotation(input logic [ELEM_WIDTH-1:0] pixel);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    rot_beat_t   beat;
    n = clamp_edge(rot_size);
    r = (rot_row >= n) ? n - 1 : rot_row;
    c = (rot_col >= n) ? n - 1 : rot_col;
    if (rot_held) begin
      beat.pixel    = rot_mem[!rot_bank][(n - 1 - c) * MAX_EDGE + r];
      beat.tile_end = (r == n - 1) && (c == n - 1);
      rotated_q.push_back(beat);
    end
    rot_mem[rot_bank][r * MAX_EDGE + c] = pixel;
    if (c + 1 < n) begin
      c++;
    end else begin
      c = 0;
      if (r + 1 < n) begin
        r++;
      end else begin
        r = 0;
        rot_bank = !rot_bank;
        rot_held = 1'b1;
      end
    end
    rot_row = r;
    rot_col = c;
  endtask

  // Prints one mismatch line, up to a cap, and counts every mismatch.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH %s: got %0h, want %0h (result %0d, cycle %0d)",
               what, got, want, results_seen, cycle_count);
  endtask

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Input driver: presents queued pixels, waiting a drawn gap before each.
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      in_gap    = draw_wait(1'b0);
    end else begin
      if (in_valid && in_ready) begin
        predict_rotation(in_pixel_in);
        pixels_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pixel_q.size() != 0) begin
          in_pixel_in <= pixel_q.pop_front();
          nxt_valid = 1'b1;
          if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
          in_gap = draw_wait(in_calm);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // Result monitor: checks each accepted beat and stalls a drawn number of
  // cycles after it.
  always @(posedge clk) begin
    logic      nxt_ready;
    rot_beat_t want;
    nxt_ready = out_ready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_tile_end) tile_ends++;
        if (rotated_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_pixel_out, 0);
        end else begin
          want = rotated_q.pop_front();
          if (out_pixel_out !== want.pixel)
            report_mismatch("pixel_out", out_pixel_out, want.pixel);
          if (out_tile_end !== want.tile_end)
            report_mismatch("tile_end", out_tile_end, want.tile_end);
        end
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    out_ready <= nxt_ready;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Waits until every queued pixel has been accepted.
  task automatic wait_sent();
    while (pixel_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  // Waits until the block is idle: all pixels sent, all results back, and
  // a few more cycles for beats that produce no result.
  task automatic settle();
    wait_sent();
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Writes the tile size register and applies the same write to the copy.
  task automatic write_tile_size(input logic [CFG_W-1:0] size);
    @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_tile_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rot_size = size;
    rot_row  = 0;
    rot_col  = 0;
    rot_held = 1'b0;
    size_writes++;
    @(negedge clk);
  endtask

  task automatic feed_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) pixel_q.push_back(ELEM_WIDTH'($urandom()));
  endtask

  // Stimulus.
  initial begin
    int unsigned      n;
    int unsigned      tiles;
    int unsigned      extra;
    int unsigned      total;
    int unsigned      room;
    int unsigned      pick;
    logic [CFG_W-1:0] size;
    bit               paused;
    paused = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size of 64: extreme pixels open the first tile, which is too
    // short to complete, so nothing may come out.
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'h8000);
    pixel_q.push_back(16'h0001);
    pixel_q.push_back(16'h7FFF);
    pixel_q.push_back(16'hFFFE);
    pixel_q.push_back(16'hAAAA);
    pixel_q.push_back(16'h5555);
    feed_pixels(24);
    settle();

    // Edge of one: every beat after the first returns the previous pixel with a tile end.
    write_tile_size(7'd1);
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'h8000);
    pixel_q.push_back(16'h0001);
    pixel_q.push_back(16'hA5A5);
    settle();

    // A size of zero behaves as an edge of one.
    write_tile_size(7'd0);
    pixel_q.push_back(16'h5555);
    pixel_q.push_back(16'hAAAA);
    pixel_q.push_back(16'h7FFF);
    settle();

    // Two by two tiles with recognizable pixels.
    write_tile_size(7'd2);
    for (int unsigned i = 0; i < 8; i++) pixel_q.push_back(ELEM_WIDTH'(16'h1000 + i));
    settle();

    // Random phases, mostly whole tiles of small sizes, some cut short.
    while (pixels_sent + SAT_ITEMS < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5)      size = CFG_W'($urandom_range(1, 5));
      else if (pick <= 7) size = CFG_W'($urandom_range(6, 12));
      else if (pick == 8) size = CFG_W'($urandom_range(13, 20));
      else                size = CFG_W'($urandom_range(0, 2));
      write_tile_size(size);
      n     = clamp_edge(size);
      tiles = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
      extra = $urandom_range(0, n * n - 1);
      total = tiles * n * n + extra;
      room  = ITEM_TARGET - SAT_ITEMS - pixels_sent;
      if (total > room) total = room;
      if (!paused && tiles >= 2 && total > n * n + extra / 2) begin
        // Let the block drain completely in the middle of a stream.
        feed_pixels(n * n + extra / 2);
        wait_sent();
        while (rotated_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        feed_pixels(total - n * n - extra / 2);
        paused = 1'b1;
      end else begin
        feed_pixels(total);
      end
      settle();
    end

    // Largest register value saturates to the full edge; the tile stays
    // partial, so no result may appear.
    write_tile_size(7'd127);
    feed_pixels(SAT_ITEMS);
    wait_sent();
    for (int unsigned i = 0; i < 5000 && rotated_q.size() != 0; i++) @(negedge clk);
    while (rotated_q.size() != 0) begin
      report_mismatch("expected result never came", 0, rotated_q[0].pixel);
      void'(rotated_q.pop_front());
    end
    repeat (SETTLE_CYC) @(negedge clk);

    $display("Sent %0d pixels over %0d tile size writes;", pixels_sent, size_writes);
    $display("checked %0d rotated pixels, %0d tile ends.", results_seen, tile_ends);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
